[sv/rme_pkg.sv]
// Shared constants, types and tables for the rotation matrix to Euler angle unit.
package rme_pkg;

  localparam int MFB      = 14;
  localparam int AFB      = 12;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 16;
  localparam int TOL_W    = 15;
  localparam int V_W      = 2 * MFB + 1;
  localparam int ROOT_W   = MFB + 1;
  localparam int XY_W     = 36;
  localparam int Z_W      = 36;
  localparam int GUARD_SH = 16;
  localparam int ROUND_SH = 30 - AFB;
  localparam int ANG_W    = Z_W - ROUND_SH + 1;
  localparam int SUM_W    = ANG_W + 2;
  localparam int NLANE    = 5;

  localparam logic [TOL_W-1:0] TOL_RESET = 15'd16;

  // CORDIC lane assignment.
  localparam int LANE_X1   = 0;
  localparam int LANE_Z1   = 1;
  localparam int LANE_X2   = 2;
  localparam int LANE_Z2   = 3;
  localparam int LANE_ASIN = 4;

  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint ONE_SQ      = 64'sd1 << (2 * MFB);

  localparam logic signed [IN_W-1:0] ONE  = IN_W'(64'sd1 << MFB);
  localparam logic signed [Z_W-1:0]  PI_Z = Z_W'(Q30_PI);
  localparam logic signed [OUT_W-1:0] HALF_PI_ANGLE =
    OUT_W'((Q30_HALF_PI + (64'sd1 << (ROUND_SH - 1))) >>> ROUND_SH);

  localparam longint ATAN_TABLE [32] = '{
    843314856, 497837829, 263043836, 133525158,
    67021686, 33543515, 16775850, 8388437,
    4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047,
    1023, 511, 255, 127,
    63, 31, 15, 8,
    4, 2, 1, 0
  };

  typedef struct packed {
    logic signed [IN_W-1:0] m11;
    logic signed [IN_W-1:0] m12;
    logic signed [IN_W-1:0] m21;
    logic signed [IN_W-1:0] m23;
    logic signed [IN_W-1:0] m31;
    logic signed [IN_W-1:0] m33;
    logic signed [IN_W-1:0] s;
    logic                   lock_neg;
    logic                   lock_pos;
  } mat_t;

  typedef struct packed {
    logic [V_W-1:0]    rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } lane_t;

  typedef struct packed {
    lane_t [NLANE-1:0] lane;
    logic              lock_neg;
    logic              lock_pos;
  } cord_t;

endpackage

[sv/rme_if.sv]
// Valid/ready channel interfaces for matrix input, angle output and configuration.
interface rme_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  m11;
  logic signed [15:0]  m12;
  logic signed [15:0]  m13;
  logic signed [15:0]  m21;
  logic signed [15:0]  m23;
  logic signed [15:0]  m31;
  logic signed [15:0]  m33;
  modport source (output valid, m11, m12, m13, m21, m23, m31, m33, input ready);
  modport sink (input valid, m11, m12, m13, m21, m23, m31, m33, output ready);
endinterface

interface rme_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;
  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface rme_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[sv/rme_sqrt_cell.sv]
// One bit of a pipelined restoring square root, carrying the matrix beside it.
module rme_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rme_pkg::mat_t mat_i,
  input  rme_pkg::sq_t  sq_i,
  output logic          valid_o,
  output rme_pkg::mat_t mat_o,
  output rme_pkg::sq_t  sq_o
);
  import rme_pkg::*;

  logic  valid_q;
  mat_t  mat_q;
  sq_t   sq_q, sq_d;
  logic [V_W:0] trial;

  // Subtracting (2*root + 2^k) * 2^k keeps rem equal to v - root^2.
  assign trial = ((V_W + 1)'(sq_i.root) << (BIT + 1)) + ((V_W + 1)'(1) << (2 * BIT));

  always_comb begin
    sq_d = sq_i;
    if (trial <= {1'b0, sq_i.rem}) begin
      sq_d.rem  = sq_i.rem - trial[V_W-1:0];
      sq_d.root = sq_i.root | (ROOT_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat_q <= mat_i;
      sq_q  <= sq_d;
    end
  end

  assign valid_o = valid_q;
  assign mat_o   = mat_q;
  assign sq_o    = sq_q;
endmodule

[sv/rme_cordic_cell.sv]
// One vectoring CORDIC iteration applied to every lane of the angle datapath.
module rme_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  rme_pkg::cord_t cord_i,
  output logic           valid_o,
  output rme_pkg::cord_t cord_o
);
  import rme_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN_Z = Z_W'(ATAN_TABLE[STAGE]);

  logic  valid_q;
  cord_t cord_q, cord_d;

  always_comb begin
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    cord_d = cord_i;
    for (int l = 0; l < NLANE; l++) begin
      xs = cord_i.lane[l].x >>> STAGE;
      ys = cord_i.lane[l].y >>> STAGE;
      if (cord_i.lane[l].y > 0) begin
        cord_d.lane[l].x = cord_i.lane[l].x + ys;
        cord_d.lane[l].y = cord_i.lane[l].y - xs;
        cord_d.lane[l].z = cord_i.lane[l].z + ATAN_Z;
      end else if (cord_i.lane[l].y < 0) begin
        cord_d.lane[l].x = cord_i.lane[l].x - ys;
        cord_d.lane[l].y = cord_i.lane[l].y + xs;
        cord_d.lane[l].z = cord_i.lane[l].z - ATAN_Z;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cord_q <= cord_d;
    end
  end

  assign valid_o = valid_q;
  assign cord_o  = cord_q;
endmodule

[sv/rotation_matrix_to_euler_unit.sv]
// Euler angles (x, y, z) in Q3.12 radians from a Q1.14 rotation matrix.
// A new matrix can be taken every clock cycle while the output is not
// stalled; each one passes through one input stage, fifteen square-root
// cells for cos(y), one quadrant stage, CORDIC_STAGES CORDIC cells, one
// rounding stage and the output register, which also makes the selection
// between the two solutions. A stall on the output freezes the whole chain.
// lock_tolerance (reset 16) is sampled as each matrix enters and should only
// be written while idle.
module rotation_matrix_to_euler_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rme_cfg_if.sink           cfg_i,
  rme_in_if.sink            in_i,
  rme_out_if.source         out_o
);
  import rme_pkg::*;

  logic advance;
  logic out_valid_q;
  logic [TOL_W-1:0] tol_q;

  assign advance     = !out_valid_q || out_o.ready;
  assign in_i.ready  = advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_i.valid) begin
      tol_q <= cfg_i.data;
    end
  end

  // Input stage: lock tests, clamp of m13 and 1 - s^2.
  logic                   s0_valid_q;
  mat_t                   s0_mat_q, s0_mat_d;
  sq_t                    s0_sq_q, s0_sq_d;
  logic signed [IN_W+1:0] d_neg, d_pos;
  logic        [IN_W+1:0] a_neg, a_pos;
  logic signed [IN_W-1:0] s_c;
  logic signed [2*IN_W-1:0] ss;

  always_comb begin
    d_neg = (IN_W + 2)'(in_i.m13) + (IN_W + 2)'(ONE);
    d_pos = (IN_W + 2)'(in_i.m13) - (IN_W + 2)'(ONE);
    a_neg = d_neg < 0 ? -d_neg : d_neg;
    a_pos = d_pos < 0 ? -d_pos : d_pos;
    s_c = in_i.m13;
    if (in_i.m13 > ONE) s_c = ONE;
    if (in_i.m13 < -ONE) s_c = -ONE;
    ss = s_c * s_c;
    s0_mat_d.m11 = in_i.m11;
    s0_mat_d.m12 = in_i.m12;
    s0_mat_d.m21 = in_i.m21;
    s0_mat_d.m23 = in_i.m23;
    s0_mat_d.m31 = in_i.m31;
    s0_mat_d.m33 = in_i.m33;
    s0_mat_d.s   = s_c;
    s0_mat_d.lock_neg = a_neg < (IN_W + 2)'(tol_q);
    s0_mat_d.lock_pos = !s0_mat_d.lock_neg && (a_pos < (IN_W + 2)'(tol_q));
    s0_sq_d.rem  = V_W'((2 * IN_W)'(ONE_SQ) - ss);
    s0_sq_d.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (advance) begin
      s0_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s0_mat_q <= s0_mat_d;
      s0_sq_q  <= s0_sq_d;
    end
  end

  // Square root chain, most significant result bit first.
  logic sq_valid [ROOT_W+1];
  mat_t sq_mat   [ROOT_W+1];
  sq_t  sq_val   [ROOT_W+1];

  assign sq_valid[0] = s0_valid_q;
  assign sq_mat[0]   = s0_mat_q;
  assign sq_val[0]   = s0_sq_q;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    rme_sqrt_cell #(.BIT(ROOT_W - 1 - j)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (sq_valid[j]),
      .mat_i   (sq_mat[j]),
      .sq_i    (sq_val[j]),
      .valid_o (sq_valid[j+1]),
      .mat_o   (sq_mat[j+1]),
      .sq_o    (sq_val[j+1])
    );
  end

  // Quadrant stage: fold x < 0 into a +-pi start angle and scale up.
  function automatic lane_t prep(input logic signed [IN_W:0] y,
                                 input logic signed [IN_W:0] x);
    lane_t l;
    logic signed [IN_W:0] xa;
    logic signed [IN_W:0] ya;
    if (x < 0) begin
      xa  = -x;
      ya  = -y;
      l.z = (y >= 0) ? PI_Z : -PI_Z;
    end else begin
      xa  = x;
      ya  = y;
      l.z = '0;
    end
    l.x = XY_W'(xa) <<< GUARD_SH;
    l.y = XY_W'(ya) <<< GUARD_SH;
    return l;
  endfunction

  mat_t  pm;
  logic  pr_valid_q;
  cord_t pr_q, pr_d;
  logic signed [IN_W:0] e11, e12, e21, e23, e31, e33;

  always_comb begin
    pm  = sq_mat[ROOT_W];
    e11 = (IN_W + 1)'(pm.m11);
    e12 = (IN_W + 1)'(pm.m12);
    e21 = (IN_W + 1)'(pm.m21);
    e23 = (IN_W + 1)'(pm.m23);
    e31 = (IN_W + 1)'(pm.m31);
    e33 = (IN_W + 1)'(pm.m33);
    pr_d.lock_neg = pm.lock_neg;
    pr_d.lock_pos = pm.lock_pos;
    pr_d.lane[LANE_X1] = prep(e23, e33);
    pr_d.lane[LANE_X2] = prep(-e23, -e33);
    pr_d.lane[LANE_Z2] = prep(-e12, -e11);
    pr_d.lane[LANE_ASIN] = prep((IN_W + 1)'(pm.s),
                                (IN_W + 1)'({1'b0, sq_val[ROOT_W].root}));
    // In gimbal lock the first z lane carries the m21/m31 arctangent.
    if (pm.lock_neg) begin
      pr_d.lane[LANE_Z1] = prep(e21, e31);
    end else if (pm.lock_pos) begin
      pr_d.lane[LANE_Z1] = prep(-e21, -e31);
    end else begin
      pr_d.lane[LANE_Z1] = prep(e12, e11);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_valid_q <= 1'b0;
    end else if (advance) begin
      pr_valid_q <= sq_valid[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pr_q <= pr_d;
    end
  end

  // CORDIC chain.
  logic  cd_valid [CORDIC_STAGES+1];
  cord_t cd_val   [CORDIC_STAGES+1];

  assign cd_valid[0] = pr_valid_q;
  assign cd_val[0]   = pr_q;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    rme_cordic_cell #(.STAGE(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (cd_valid[i]),
      .cord_i  (cd_val[i]),
      .valid_o (cd_valid[i+1]),
      .cord_o  (cd_val[i+1])
    );
  end

  // Rounding stage: half away from zero to the output fraction.
  function automatic logic signed [ANG_W-1:0] to_angle(input logic signed [Z_W-1:0] z);
    logic [Z_W-1:0] mag;
    logic [Z_W-1:0] r;
    mag = z[Z_W-1] ? Z_W'(-z) : Z_W'(z);
    r   = (mag + (Z_W'(1) << (ROUND_SH - 1))) >> ROUND_SH;
    return z[Z_W-1] ? -$signed(r[ANG_W-1:0]) : $signed(r[ANG_W-1:0]);
  endfunction

  cord_t cf;
  logic  rd_valid_q;
  logic  rd_lock_neg_q, rd_lock_pos_q;
  logic signed [ANG_W-1:0] x1_q, y1_q, z1_q, x2_q, y2_q, z2_q;

  assign cf = cd_val[CORDIC_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (advance) begin
      rd_valid_q <= cd_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rd_lock_neg_q <= cf.lock_neg;
      rd_lock_pos_q <= cf.lock_pos;
      x1_q <= to_angle(cf.lane[LANE_X1].z);
      z1_q <= to_angle(cf.lane[LANE_Z1].z);
      x2_q <= to_angle(cf.lane[LANE_X2].z);
      z2_q <= to_angle(cf.lane[LANE_Z2].z);
      y1_q <= -to_angle(cf.lane[LANE_ASIN].z);
      y2_q <= to_angle(PI_Z + cf.lane[LANE_ASIN].z);
    end
  end

  // Selection stage into the output register.
  function automatic logic [SUM_W-1:0] mag(input logic signed [ANG_W-1:0] a);
    return SUM_W'(a < 0 ? -a : a);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [ANG_W-1:0] a);
    if (a > ANG_W'(32767)) return 16'sd32767;
    if (a < -ANG_W'(32768)) return -16'sd32768;
    return a[OUT_W-1:0];
  endfunction

  logic signed [OUT_W-1:0] ax_q, ay_q, az_q, ax_d, ay_d, az_d;
  logic        [SUM_W-1:0] sum1, sum2;

  always_comb begin
    sum1 = mag(x1_q) + mag(y1_q) + mag(z1_q);
    sum2 = mag(x2_q) + mag(y2_q) + mag(z2_q);
    if (rd_lock_neg_q || rd_lock_pos_q) begin
      ax_d = '0;
      ay_d = rd_lock_neg_q ? HALF_PI_ANGLE : -HALF_PI_ANGLE;
      az_d = sat(z1_q);
    end else if (sum1 <= sum2) begin
      ax_d = sat(x1_q);
      ay_d = sat(y1_q);
      az_d = sat(z1_q);
    end else begin
      ax_d = sat(x2_q);
      ay_d = sat(y2_q);
      az_d = sat(z2_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= rd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
      az_q <= az_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.angle_x = ax_q;
  assign out_o.angle_y = ay_q;
  assign out_o.angle_z = az_q;

`ifndef ASSERT_OFF
  a_lock_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_valid_q |-> !(s0_mat_q.lock_neg && s0_mat_q.lock_pos))
    else $error("both gimbal lock flags set");

  a_sqrt_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid[ROOT_W] |-> ((V_W + 1)'(sq_val[ROOT_W].rem) <=
                          ((V_W + 1)'(sq_val[ROOT_W].root) << 1)))
    else $error("square root remainder out of range");

  a_cordic_x_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cd_valid[CORDIC_STAGES] |-> (cf.lane[LANE_X1].x >= 0 && cf.lane[LANE_ASIN].x >= 0))
    else $error("CORDIC x went negative");
`endif
endmodule

[dv/rme_tb_if.sv]
// Testbench-side note: the channel interfaces themselves come from the RTL file rme_if.sv.
package rme_tb_pkg;
  import rme_pkg::*;

  typedef struct {
    logic signed [15:0] m11, m12, m13, m21, m23, m31, m33;
  } matrix_t;

  typedef struct {
    logic signed [15:0] ax, ay, az;
  } angles_t;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam int     N_STAGES    = 16;

  localparam longint ARCTAN_Q30 [16] = '{
    843314856, 497837829, 263043836, 133525158,
    67021686, 33543515, 16775850, 8388437,
    4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767
  };

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q30 : -PI_Q30;
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < N_STAGES; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += ARCTAN_Q30[i];
      end else if (y < 0) begin
        x -= ys; y += xs; z -= ARCTAN_Q30[i];
      end
    end
    return z;
  endfunction

  function automatic longint round_angle(longint q);
    longint m, r;
    m = q < 0 ? -q : q;
    r = (m + (64'sd1 << 17)) >>> 18;
    return q < 0 ? -r : r;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint iabs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic angles_t euler_angles(matrix_t m, int tol);
    longint one, s, c, yq, x1, y1, z1, x2, y2, z2, ax, ay, az;
    angles_t r;
    one = 16384;
    if (iabs(longint'(m.m13) + one) < tol) begin
      ax = 0;
      ay = round_angle(HALF_PI_Q30);
      az = round_angle(vector_angle(m.m21, m.m31));
    end else if (iabs(longint'(m.m13) - one) < tol) begin
      ax = 0;
      ay = round_angle(-HALF_PI_Q30);
      az = round_angle(vector_angle(-longint'(m.m21), -longint'(m.m31)));
    end else begin
      s = m.m13;
      if (s > one) s = one;
      if (s < -one) s = -one;
      c = int_sqrt(one * one - s * s);
      yq = -vector_angle(s, c);
      x1 = round_angle(vector_angle(m.m23, m.m33));
      y1 = round_angle(yq);
      z1 = round_angle(vector_angle(m.m12, m.m11));
      x2 = round_angle(vector_angle(-longint'(m.m23), -longint'(m.m33)));
      y2 = round_angle(PI_Q30 - yq);
      z2 = round_angle(vector_angle(-longint'(m.m12), -longint'(m.m11)));
      if (iabs(x1) + iabs(y1) + iabs(z1) <= iabs(x2) + iabs(y2) + iabs(z2)) begin
        ax = x1; ay = y1; az = z1;
      end else begin
        ax = x2; ay = y2; az = z2;
      end
    end
    r.ax = clamp16(ax);
    r.ay = clamp16(ay);
    r.az = clamp16(az);
    return r;
  endfunction
endpackage

[dv/rotation_matrix_to_euler_unit_tb.sv]
// Self-checking testbench for the rotation matrix to Euler angle unit.
module rotation_matrix_to_euler_unit_tb;
  import rme_tb_pkg::*;

  class angle_scoreboard;
    angles_t pending_angles[$];
    int      lock_tol = 16;
    int      errors;
    int      checked;

    function void note_matrix(matrix_t m);
      pending_angles.push_back(euler_angles(m, lock_tol));
    endfunction

    function void check_angles(angles_t got);
      angles_t exp_a;
      if (pending_angles.size() == 0) begin
        $error("angle beat with nothing expected");
        errors++;
        return;
      end
      exp_a = pending_angles.pop_front();
      checked++;
      if (got.ax !== exp_a.ax) begin
        $error("angle_x expected %0d got %0d", exp_a.ax, got.ax); errors++;
      end
      if (got.ay !== exp_a.ay) begin
        $error("angle_y expected %0d got %0d", exp_a.ay, got.ay); errors++;
      end
      if (got.az !== exp_a.az) begin
        $error("angle_z expected %0d got %0d", exp_a.az, got.az); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  rme_cfg_if cfg_ch();
  rme_in_if  in_ch();
  rme_out_if out_ch();

  rotation_matrix_to_euler_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_ch.sink), .in_i(in_ch.sink),
    .out_o(out_ch.source)
  );

  angle_scoreboard sb = new();
  int  cycle_count;
  bit  hold_off;
  bit  calm;
  int  lock_cases;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cfg_ch.valid = 0; cfg_ch.data = 0;
    in_ch.valid = 0;
    in_ch.m11 = 0; in_ch.m12 = 0; in_ch.m13 = 0; in_ch.m21 = 0;
    in_ch.m23 = 0; in_ch.m31 = 0; in_ch.m33 = 0;
    out_ch.ready = 0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_angles('{out_ch.angle_x, out_ch.angle_y, out_ch.angle_z});
    out_ch.ready <= !hold_off && (calm || $urandom_range(99) >= 19);
  end

  task automatic write_tolerance(int tol);
    cfg_ch.data  <= 15'(tol);
    cfg_ch.valid <= 1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    sb.lock_tol = tol;
  endtask

  task automatic send_matrix(matrix_t m);
    while (!calm && $urandom_range(99) < 19) begin
      in_ch.valid <= 0;
      @(posedge clk_i);
    end
    in_ch.m11 <= m.m11; in_ch.m12 <= m.m12; in_ch.m13 <= m.m13;
    in_ch.m21 <= m.m21; in_ch.m23 <= m.m23; in_ch.m31 <= m.m31;
    in_ch.m33 <= m.m33;
    in_ch.valid <= 1;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_matrix(m);
    if (iabs(longint'(m.m13) + 16384) < sb.lock_tol ||
        iabs(longint'(m.m13) - 16384) < sb.lock_tol)
      lock_cases++;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending_angles.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] any_elem();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic matrix_t random_matrix(int tol);
    matrix_t m;
    m = '{any_elem(), any_elem(), any_elem(), any_elem(), any_elem(),
          any_elem(), any_elem()};
    // Push m13 toward the lock band now and then.
    if ($urandom_range(3) == 0)
      m.m13 = 16'(($urandom_range(1) ? 16384 : -16384) +
                  $signed($urandom_range(2 * tol + 4)) - tol - 2);
    return m;
  endfunction

  task automatic run_random(int n, int tol);
    for (int i = 0; i < n; i++) send_matrix(random_matrix(tol));
    drain();
  endtask

  initial begin
    int tols[4] = '{0, 16384, 300, 1};
    hold_off = 0;
    calm = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes, lock bands at reset tolerance, zero arguments.
    send_matrix('{16384, 0, 0, 0, 0, 0, 16384});
    send_matrix('{0, 0, 0, 0, 0, 0, 0});
    send_matrix('{-16384, 0, 0, 0, 0, -16384, -16384});
    send_matrix('{-16384, -16384, -16384, -16384, -16384, -16384, -16384});
    send_matrix('{16384, 16384, 16384, 16384, 16384, 16384, 16384});
    send_matrix('{0, 0, -16369, 100, 0, -200, 0});
    send_matrix('{0, 0, -16368, 100, 0, 0, 0});
    send_matrix('{0, 0, 16369, -100, 0, 200, 0});
    send_matrix('{0, 0, 16368, 0, 0, -5, 0});
    send_matrix('{-32768, 32767, -32768, 32767, -32768, 32767, -32768});
    send_matrix('{32767, -32768, 32767, -32768, 32767, -32768, 32767});
    send_matrix('{-5, 0, 0, 0, 0, 0, -7});
    send_matrix('{11585, 11585, 8192, -11585, 11585, 0, -11585});
    drain();

    write_tolerance(0);
    send_matrix('{0, 0, 16384, 0, 0, 0, 0});
    send_matrix('{0, 0, -16384, 0, 0, 0, 0});
    drain();

    calm = 1;
    hold_off = 1;
    fork
      begin
        repeat (200) @(posedge clk_i);
        hold_off = 0;
      end
      for (int i = 0; i < 80; i++) send_matrix(random_matrix(1));
    join
    drain();
    calm = 0;

    foreach (tols[k]) begin
      write_tolerance(tols[k]);
      run_random(170, tols[k] == 16384 ? 200 : tols[k]);
    end
    write_tolerance(16);
    run_random(40, 16);

    $display("Checked %0d angle beats over several lock tolerances, %0d near gimbal lock.",
             sb.checked, lock_cases);
    if (sb.errors == 0 && sb.pending_angles.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

[rotation_matrix_to_euler_unit.f]
sv/rme_pkg.sv
sv/rme_if.sv
sv/rme_sqrt_cell.sv
sv/rme_cordic_cell.sv
sv/rotation_matrix_to_euler_unit.sv
dv/rme_tb_if.sv
dv/rotation_matrix_to_euler_unit_tb.sv
